### design/vga_pkg.sv
// Shared types, operation codes and arithmetic helpers of the vector geometry ALU.
`timescale 1ns / 1ps

package vga_pkg;

    // Operation codes carried in the func field.
    localparam logic [3:0] FN_ADD       = 4'd0;
    localparam logic [3:0] FN_SUB       = 4'd1;
    localparam logic [3:0] FN_MUL       = 4'd2;
    localparam logic [3:0] FN_SCALE     = 4'd3;
    localparam logic [3:0] FN_DOT       = 4'd4;
    localparam logic [3:0] FN_LENSQ     = 4'd5;
    localparam logic [3:0] FN_LENGTH    = 4'd6;
    localparam logic [3:0] FN_NORMALIZE = 4'd7;
    localparam logic [3:0] FN_PROJECT   = 4'd8;
    localparam logic [3:0] FN_REJECT    = 4'd9;

    // One square-root stage per result bit, one divider stage per quotient bit.
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 33;

    localparam logic [30:0] THR_RESET = 31'd1;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] q_t;
    typedef q_t [2:0] vec_t;

    typedef struct packed {
        logic [3:0] func;
        q_t         first_x;
        q_t         first_y;
        q_t         first_z;
        q_t         second_x;
        q_t         second_y;
        q_t         second_z;
        q_t         scale_factor;
    } in_item_t;

    typedef struct packed {
        q_t   out_x;
        q_t   out_y;
        q_t   out_z;
        q_t   out_scalar;
        logic saturated;
        logic degenerate;
    } out_item_t;

    // Clipped value together with its overflow flag.
    typedef struct packed {
        q_t   val;
        logic sat;
    } clip_t;

    // Item context that travels along the long part of the pipeline.
    typedef struct packed {
        logic [3:0]         func;
        vec_t               a;
        vec_t               b;
        vec_t               ev;
        q_t                 esc;
        logic               esat;
        logic               deg;
        logic [47:0]        lsq;
        logic signed [49:0] dot;
        logic [32:0]        len;
    } ctx_t;

    // State of one divider lane.
    typedef struct packed {
        logic [47:0] den;
        logic [47:0] p;
        logic [32:0] rest;
        logic [32:0] q;
        logic        ovf;
        logic        neg;
    } div_lane_t;

    typedef div_lane_t [2:0] div_lanes_t;

    // Magnitude of a Q16.16 value; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? 32'(-x) : 32'(x);
        return r;
    endfunction

    // Saturate a wide signed value to the 32-bit range.
    function automatic clip_t clip32(input logic signed [63:0] v);
        clip_t c;
        if (v > 64'sd2147483647) begin
            c.val = Q_MAX;
            c.sat = 1'b1;
        end
        else if (v < -64'sd2147483648) begin
            c.val = Q_MIN;
            c.sat = 1'b1;
        end
        else begin
            c.val = v[31:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

    // Round a magnitude product to Q16.16, half away from zero, and apply the sign.
    function automatic logic signed [47:0] rnd_q(input logic [63:0] m, input logic neg);
        logic [63:0]        r;
        logic signed [47:0] s;
        r = (m + 64'd32768) >> 16;
        s = r[47:0];
        return neg ? -s : s;
    endfunction

endpackage

### design/vga_ifs.sv
// Channel interfaces of the vector geometry ALU: commands, responses and configuration.
`timescale 1ns / 1ps

interface vga_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] scale_factor;

    modport source (
        output valid, func, first_x, first_y, first_z,
               second_x, second_y, second_z, scale_factor,
        input  ready
    );
    modport sink (
        input  valid, func, first_x, first_y, first_z,
               second_x, second_y, second_z, scale_factor,
        output ready
    );
endinterface

interface vga_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_scalar;
    logic        saturated;
    logic        degenerate;

    modport source (
        output valid, out_x, out_y, out_z, out_scalar, saturated, degenerate,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_scalar, saturated, degenerate,
        output ready
    );
endinterface

interface vga_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

### design/vga_datapath.sv
// Pipelined datapath: products, sums, square root, division and result selection.
`timescale 1ns / 1ps

module vga_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  vga_pkg::in_item_t   in_item,
    input  logic [30:0]         thr,
    output logic                out_valid,
    output vga_pkg::out_item_t  out_item
);
    import vga_pkg::*;

    // ------------------------------------------------------------------
    // Stage 1: magnitude products.
    // ------------------------------------------------------------------
    vec_t        in_a;
    vec_t        in_b;
    logic [31:0] am [3];
    logic [31:0] bm [3];
    logic [31:0] opm [3];
    logic        ab_neg_next [3];
    logic [63:0] ab_next [3];
    logic [63:0] aa_next [3];
    logic [63:0] bb_next [3];

    logic        s1_v_reg;
    logic [3:0]  s1_func_reg;
    vec_t        s1_a_reg;
    vec_t        s1_b_reg;
    logic [63:0] s1_ab_reg [3];
    logic [63:0] s1_aa_reg [3];
    logic [63:0] s1_bb_reg [3];
    logic        s1_abn_reg [3];

    // The a*b multipliers take the scalar instead of b for a scale.
    always_comb
    begin
        in_a = {in_item.first_z, in_item.first_y, in_item.first_x};
        in_b = {in_item.second_z, in_item.second_y, in_item.second_x};
        for (int i = 0; i < 3; i++)
        begin
            am[i] = mag32(in_a[i]);
            bm[i] = mag32(in_b[i]);
            if (in_item.func == FN_SCALE)
            begin
                opm[i]         = mag32(in_item.scale_factor);
                ab_neg_next[i] = in_a[i][31] ^ in_item.scale_factor[31];
            end
            else
            begin
                opm[i]         = bm[i];
                ab_neg_next[i] = in_a[i][31] ^ in_b[i][31];
            end
            ab_next[i] = am[i] * opm[i];
            aa_next[i] = am[i] * am[i];
            bb_next[i] = bm[i] * bm[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_func_reg <= in_item.func;
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
            for (int i = 0; i < 3; i++)
            begin
                s1_ab_reg[i]  <= ab_next[i];
                s1_aa_reg[i]  <= aa_next[i];
                s1_bb_reg[i]  <= bb_next[i];
                s1_abn_reg[i] <= ab_neg_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round products to Q16.16.
    // ------------------------------------------------------------------
    logic               s2_v_reg;
    logic [3:0]         s2_func_reg;
    vec_t               s2_a_reg;
    vec_t               s2_b_reg;
    logic signed [47:0] s2_ab_reg [3];
    logic signed [47:0] s2_aa_reg [3];
    logic signed [47:0] s2_bb_reg [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s2_func_reg <= s1_func_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_ab_reg[i] <= rnd_q(s1_ab_reg[i], s1_abn_reg[i]);
                s2_aa_reg[i] <= rnd_q(s1_aa_reg[i], 1'b0);
                s2_bb_reg[i] <= rnd_q(s1_bb_reg[i], 1'b0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums, simple results and the degenerate test.
    // ------------------------------------------------------------------
    logic signed [49:0] dot_s;
    logic signed [49:0] lsqa_s;
    logic signed [49:0] lsqb_s;
    logic [47:0]        lsq_sel;
    logic               is_deg;
    clip_t              c_add [3];
    clip_t              c_sub [3];
    clip_t              c_mul [3];
    clip_t              c_dot;
    clip_t              c_lsq;
    ctx_t               ctx3_next;

    always_comb
    begin
        dot_s  = 50'(s2_ab_reg[0]) + 50'(s2_ab_reg[1]) + 50'(s2_ab_reg[2]);
        lsqa_s = 50'(s2_aa_reg[0]) + 50'(s2_aa_reg[1]) + 50'(s2_aa_reg[2]);
        lsqb_s = 50'(s2_bb_reg[0]) + 50'(s2_bb_reg[1]) + 50'(s2_bb_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            c_add[i] = clip32(64'($signed(s2_a_reg[i])) + 64'($signed(s2_b_reg[i])));
            c_sub[i] = clip32(64'($signed(s2_a_reg[i])) - 64'($signed(s2_b_reg[i])));
            c_mul[i] = clip32(64'(s2_ab_reg[i]));
        end
        c_dot = clip32(64'(dot_s));
        c_lsq = clip32(64'(lsqa_s));

        // Length and normalize test a, project and reject test b.
        lsq_sel = (s2_func_reg inside {FN_LENGTH, FN_NORMALIZE}) ? lsqa_s[47:0] : lsqb_s[47:0];
        is_deg  = (lsq_sel == 48'd0) || (lsq_sel < {17'd0, thr});

        ctx3_next      = '0;
        ctx3_next.func = s2_func_reg;
        ctx3_next.a    = s2_a_reg;
        ctx3_next.b    = s2_b_reg;
        ctx3_next.lsq  = lsq_sel;
        ctx3_next.dot  = dot_s;
        case (s2_func_reg)
            FN_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctx3_next.ev[i] = c_add[i].val;
                end
                ctx3_next.esat = c_add[0].sat | c_add[1].sat | c_add[2].sat;
            end
            FN_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctx3_next.ev[i] = c_sub[i].val;
                end
                ctx3_next.esat = c_sub[0].sat | c_sub[1].sat | c_sub[2].sat;
            end
            FN_MUL, FN_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctx3_next.ev[i] = c_mul[i].val;
                end
                ctx3_next.esat = c_mul[0].sat | c_mul[1].sat | c_mul[2].sat;
            end
            FN_DOT:
            begin
                ctx3_next.esc  = c_dot.val;
                ctx3_next.esat = c_dot.sat;
            end
            FN_LENSQ:
            begin
                ctx3_next.esc  = c_lsq.val;
                ctx3_next.esat = c_lsq.sat;
            end
            FN_LENGTH, FN_NORMALIZE, FN_PROJECT, FN_REJECT:
            begin
                ctx3_next.deg = is_deg;
            end
            default:
            begin
                ctx3_next.deg = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Square root of lsq * 2^16, one result bit per stage.
    // Index 0 is the stage 3 register.
    // ------------------------------------------------------------------
    logic [SQ_STEPS:0] sq_v_reg;
    ctx_t              sq_ctx_reg  [SQ_STEPS+1];
    logic [63:0]       sq_n_reg    [SQ_STEPS+1];
    logic [33:0]       sq_rem_reg  [SQ_STEPS+1];
    logic [31:0]       sq_root_reg [SQ_STEPS+1];
    logic [63:0]       sq_n_next    [SQ_STEPS+1];
    logic [33:0]       sq_rem_next  [SQ_STEPS+1];
    logic [31:0]       sq_root_next [SQ_STEPS+1];

    always_comb
    begin
        logic [35:0] t;
        logic [35:0] trial;
        logic        ge;
        sq_n_next[0]    = {ctx3_next.lsq, 16'd0};
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            t               = {sq_rem_reg[k-1], sq_n_reg[k-1][63:62]};
            trial           = {2'b00, sq_root_reg[k-1], 2'b01};
            ge              = (t >= trial);
            sq_rem_next[k]  = ge ? 34'(t - trial) : t[33:0];
            sq_root_next[k] = {sq_root_reg[k-1][30:0], ge};
            sq_n_next[k]    = {sq_n_reg[k-1][61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq_ctx_reg[0] <= ctx3_next;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sq_ctx_reg[k] <= sq_ctx_reg[k-1];
            end
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_n_reg[k]    <= sq_n_next[k];
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Round the root to nearest.
    // ------------------------------------------------------------------
    logic r1_v_reg;
    ctx_t r1_ctx_reg;
    ctx_t r1_ctx_next;

    always_comb
    begin
        r1_ctx_next     = sq_ctx_reg[SQ_STEPS];
        r1_ctx_next.len = {1'b0, sq_root_reg[SQ_STEPS]}
                        + {32'd0, sq_rem_reg[SQ_STEPS] > {2'b00, sq_root_reg[SQ_STEPS]}};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r1_ctx_reg <= r1_ctx_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider setup. Normalize divides each |a| * 2^16 by the length;
    // project and reject divide |dot| * 2^16 by lsq in lane 0.
    // Index 0 is this setup register.
    // ------------------------------------------------------------------
    logic [DIV_STEPS:0] dv_v_reg;
    ctx_t               dv_ctx_reg  [DIV_STEPS+1];
    div_lanes_t         dv_lane_reg [DIV_STEPS+1];
    div_lanes_t         dv_lane_next [DIV_STEPS+1];

    always_comb
    begin
        logic [63:0] num;
        logic [49:0] dmag;
        logic [48:0] t;
        logic        ge;
        dmag = r1_ctx_reg.dot[49] ? 50'(-r1_ctx_reg.dot) : 50'(r1_ctx_reg.dot);
        for (int i = 0; i < 3; i++)
        begin
            if (r1_ctx_reg.func inside {FN_PROJECT, FN_REJECT})
            begin
                num                      = (i == 0) ? {dmag[47:0], 16'd0} : 64'd0;
                dv_lane_next[0][i].den  = r1_ctx_reg.lsq;
                dv_lane_next[0][i].neg  = r1_ctx_reg.dot[49];
            end
            else
            begin
                num                      = {16'd0, mag32(r1_ctx_reg.a[i]), 16'd0};
                dv_lane_next[0][i].den  = {16'd0, r1_ctx_reg.len[31:0]};
                dv_lane_next[0][i].neg  = r1_ctx_reg.a[i][31];
            end
            dv_lane_next[0][i].ovf  = ({17'd0, num[63:33]} >= dv_lane_next[0][i].den);
            dv_lane_next[0][i].p    = {17'd0, num[63:33]};
            dv_lane_next[0][i].rest = num[32:0];
            dv_lane_next[0][i].q    = '0;
        end

        // Restoring division, one quotient bit per stage.
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_lane_next[k][i]      = dv_lane_reg[k-1][i];
                t                       = {dv_lane_reg[k-1][i].p, dv_lane_reg[k-1][i].rest[32]};
                ge                      = (t >= {1'b0, dv_lane_reg[k-1][i].den});
                dv_lane_next[k][i].p    = ge ? 48'(t - {1'b0, dv_lane_reg[k-1][i].den})
                                             : t[47:0];
                dv_lane_next[k][i].q    = {dv_lane_reg[k-1][i].q[31:0], ge};
                dv_lane_next[k][i].rest = {dv_lane_reg[k-1][i].rest[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dv_ctx_reg[0] <= r1_ctx_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dv_ctx_reg[k] <= dv_ctx_reg[k-1];
            end
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_lane_reg[k] <= dv_lane_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Round quotients, apply signs and clip.
    // ------------------------------------------------------------------
    logic  f_v_reg;
    ctx_t  f_ctx_reg;
    vec_t  f_nv_reg;
    logic  [2:0] f_nsat_reg;
    clip_t lane_c [3];

    always_comb
    begin
        div_lane_t ln;
        logic      rup;
        logic [33:0] qr;
        for (int i = 0; i < 3; i++)
        begin
            ln  = dv_lane_reg[DIV_STEPS][i];
            rup = ({ln.p, 1'b0} >= {1'b0, ln.den});
            qr  = {1'b0, ln.q} + {33'd0, rup};
            if (ln.ovf)
            begin
                lane_c[i].val = ln.neg ? Q_MIN : Q_MAX;
                lane_c[i].sat = 1'b1;
            end
            else
            begin
                lane_c[i] = clip32(ln.neg ? -64'(qr) : 64'(qr));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f_ctx_reg <= dv_ctx_reg[DIV_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                f_nv_reg[i]   <= lane_c[i].val;
                f_nsat_reg[i] <= lane_c[i].sat;
            end
        end
    end

    // ------------------------------------------------------------------
    // Projection products b * factor; the factor is lane 0.
    // ------------------------------------------------------------------
    logic        m_v_reg;
    ctx_t        m_ctx_reg;
    vec_t        m_nv_reg;
    logic [2:0]  m_nsat_reg;
    logic        m_fsat_reg;
    logic [63:0] m_pm_reg [3];
    logic        m_pneg_reg [3];
    logic [31:0] fm;
    logic [31:0] pbm [3];
    logic [63:0] pm_next [3];

    always_comb
    begin
        fm = mag32(f_nv_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            pbm[i]     = mag32(f_ctx_reg.b[i]);
            pm_next[i] = pbm[i] * fm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m_ctx_reg  <= f_ctx_reg;
            m_nv_reg   <= f_nv_reg;
            m_nsat_reg <= f_nsat_reg;
            m_fsat_reg <= f_nsat_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                m_pm_reg[i]   <= pm_next[i];
                m_pneg_reg[i] <= f_ctx_reg.b[i][31] ^ f_nv_reg[0][31];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final selection per operation.
    // ------------------------------------------------------------------
    logic      o_v_reg;
    out_item_t o_item_reg;
    out_item_t o_item_next;
    clip_t     cp [3];
    clip_t     rj [3];
    clip_t     c_len;
    vec_t      v_sel;

    always_comb
    begin
        logic signed [47:0] pr;
        for (int i = 0; i < 3; i++)
        begin
            pr    = rnd_q(m_pm_reg[i], m_pneg_reg[i]);
            cp[i] = clip32(64'(pr));
            rj[i] = clip32(64'($signed(m_ctx_reg.a[i])) - 64'(cp[i].val));
        end
        c_len = clip32({31'd0, m_ctx_reg.len});

        v_sel       = '0;
        o_item_next = '0;
        case (m_ctx_reg.func)
            FN_ADD, FN_SUB, FN_MUL, FN_SCALE:
            begin
                v_sel                 = m_ctx_reg.ev;
                o_item_next.saturated = m_ctx_reg.esat;
            end
            FN_DOT, FN_LENSQ:
            begin
                o_item_next.out_scalar = m_ctx_reg.esc;
                o_item_next.saturated  = m_ctx_reg.esat;
            end
            FN_LENGTH:
            begin
                o_item_next.degenerate = m_ctx_reg.deg;
                if (!m_ctx_reg.deg)
                begin
                    o_item_next.out_scalar = c_len.val;
                    o_item_next.saturated  = c_len.sat;
                end
            end
            FN_NORMALIZE:
            begin
                o_item_next.degenerate = m_ctx_reg.deg;
                if (m_ctx_reg.deg)
                begin
                    v_sel = m_ctx_reg.a;
                end
                else
                begin
                    v_sel                 = m_nv_reg;
                    o_item_next.saturated = |m_nsat_reg;
                end
            end
            FN_PROJECT:
            begin
                o_item_next.degenerate = m_ctx_reg.deg;
                if (!m_ctx_reg.deg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        v_sel[i] = cp[i].val;
                    end
                    o_item_next.saturated = m_fsat_reg | cp[0].sat | cp[1].sat | cp[2].sat;
                end
            end
            FN_REJECT:
            begin
                o_item_next.degenerate = m_ctx_reg.deg;
                if (m_ctx_reg.deg)
                begin
                    v_sel = m_ctx_reg.a;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        v_sel[i] = rj[i].val;
                    end
                    o_item_next.saturated = m_fsat_reg | cp[0].sat | cp[1].sat | cp[2].sat
                                          | rj[0].sat | rj[1].sat | rj[2].sat;
                end
            end
            default:
            begin
                v_sel = '0;
            end
        endcase
        o_item_next.out_x = v_sel[0];
        o_item_next.out_y = v_sel[1];
        o_item_next.out_z = v_sel[2];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            o_item_reg <= o_item_next;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            sq_v_reg <= '0;
            r1_v_reg <= 1'b0;
            dv_v_reg <= '0;
            f_v_reg  <= 1'b0;
            m_v_reg  <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (ce)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            sq_v_reg <= {sq_v_reg[SQ_STEPS-1:0], s2_v_reg};
            r1_v_reg <= sq_v_reg[SQ_STEPS];
            dv_v_reg <= {dv_v_reg[DIV_STEPS-1:0], r1_v_reg};
            f_v_reg  <= dv_v_reg[DIV_STEPS];
            m_v_reg  <= f_v_reg;
            o_v_reg  <= m_v_reg;
        end
    end

    assign out_valid = o_v_reg;
    assign out_item  = o_item_reg;

endmodule

### design/vec3_geometry_alu_top.sv
// Top level of the vector geometry ALU: channels, threshold register and output skid.
//
// Usage:
//   cmd carries func, vectors a (first_*), b (second_*) and scale_factor, all
//   signed Q16.16. rsp returns out_x/y/z, out_scalar and the saturated and
//   degenerate flags, one response per command, in command order.
//   cfg writes the 31-bit squared-length threshold; it is always ready and
//   should be written only while no command is in flight.
// Pipeline: a command passes through the multiply, round and sum stages,
//   32 square-root stages (one root bit
//   each), two setup stages, 33 divider stages (one quotient bit each) and
//   three stages of rounding, projection multiply and result selection.
// Throughput: one command per cycle while rsp is taken every cycle.
// Reset: all valid bits clear, the pipeline is empty and the threshold
//   returns to 1.
// Stall: when rsp is not taken, the waiting response moves into a skid
//   register and the pipeline still advances once; after that the whole
//   pipeline holds and cmd.ready drops until the skid register drains.
`timescale 1ns / 1ps

module vec3_geometry_alu_top (
    input  logic   clk,
    input  logic   rst_n,
    vga_cmd_if.sink   cmd,
    vga_rsp_if.source rsp,
    vga_cfg_if.sink   cfg
);
    import vga_pkg::*;

    logic      ce;
    logic      pipe_valid;
    in_item_t  in_item;
    out_item_t pipe_item;
    out_item_t shown_item;
    logic [30:0] thr_reg;
    logic      skid_full_reg;
    logic      skid_full_next;
    out_item_t skid_reg;

    // Threshold register, written by every cfg transfer.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            thr_reg <= cfg.data;
        end
    end

    // Pipeline advances whenever the skid register is free.
    assign ce        = !skid_full_reg;
    assign cmd.ready = ce;

    always_comb
    begin
        in_item.func         = cmd.func;
        in_item.first_x      = cmd.first_x;
        in_item.first_y      = cmd.first_y;
        in_item.first_z      = cmd.first_z;
        in_item.second_x     = cmd.second_x;
        in_item.second_y     = cmd.second_y;
        in_item.second_z     = cmd.second_z;
        in_item.scale_factor = cmd.scale_factor;
    end

    vga_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (cmd.valid),
        .in_item   (in_item),
        .thr       (thr_reg),
        .out_valid (pipe_valid),
        .out_item  (pipe_item)
    );

    // Skid register catches a response that is not taken while the pipeline moves.
    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg)
        begin
            if (rsp.ready)
            begin
                skid_full_next = 1'b0;
            end
        end
        else if (pipe_valid && !rsp.ready)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_reg <= pipe_item;
        end
    end

    // Response channel shows the skid entry first.
    assign shown_item     = skid_full_reg ? skid_reg : pipe_item;
    assign rsp.valid      = skid_full_reg || pipe_valid;
    assign rsp.out_x      = shown_item.out_x;
    assign rsp.out_y      = shown_item.out_y;
    assign rsp.out_z      = shown_item.out_z;
    assign rsp.out_scalar = shown_item.out_scalar;
    assign rsp.saturated  = shown_item.saturated;
    assign rsp.degenerate = shown_item.degenerate;

endmodule

### design/vga_checker.sv
// Port-level checker for the vector geometry ALU and its bind to the top level.
`timescale 1ns / 1ps

module vga_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_x,
    input logic [31:0] rsp_y,
    input logic [31:0] rsp_z,
    input logic [31:0] rsp_scalar,
    input logic        rsp_sat,
    input logic        rsp_deg
);

    // A response that is shown stays until its transfer.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    // A stalled response keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_z)
                                    && $stable(rsp_scalar) && $stable(rsp_sat)
                                    && $stable(rsp_deg))
        else $error("stalled response changed");

    // Once a response stalls, the skid entry is occupied and commands are held off.
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> !cmd_ready)
        else $error("command taken with a full skid entry");

    // With no response on show the skid entry is empty, so commands flow.
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> cmd_ready)
        else $error("commands blocked with no response pending");

endmodule

bind vec3_geometry_alu_top vga_checker u_vga_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_x      (rsp.out_x),
    .rsp_y      (rsp.out_y),
    .rsp_z      (rsp.out_z),
    .rsp_scalar (rsp.out_scalar),
    .rsp_sat    (rsp.saturated),
    .rsp_deg    (rsp.degenerate)
);

### test/tb_vec3_geometry_alu_top.sv
// Testbench of the vector geometry ALU: directed table, random streams and a predictor.
`timescale 1ns / 1ps

module tb_vec3_geometry_alu_top;
    import vga_pkg::*;

    localparam int LATENCY = 73;
    localparam int N_RANDOM = 1400;

    // One stimulus row: the command, an optional typed-in result and its use flag.
    typedef struct {
        in_item_t  cmd;
        logic      has_known;
        out_item_t known;
    } stim_row_t;

    logic clk;
    logic rst_n;
    vga_cmd_if cmd_ch ();
    vga_rsp_if rsp_ch ();
    vga_cfg_if cfg_ch ();

    logic [30:0] threshold;
    out_item_t   pending_results[$];
    int          error_count;
    int          result_count;
    logic        stall_mode = 1'b0;

    vec3_geometry_alu_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end
    always #6 clk = ~clk;

    // Overall time limit.
    initial
    begin
        #(12 * 4000000);
        $display("Some tests failed");
        $finish;
    end

    // Rounded Q16.16 product, half away from zero.
    function automatic logic signed [63:0] q_mul(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
        logic [63:0] m;
        m = (x < 0 ? -x : x) * (y < 0 ? -y : y);
        m = (m + 64'd32768) >> 16;
        return ((x < 0) != (y < 0)) ? -$signed(m) : $signed(m);
    endfunction

    // Quotient rounded to nearest on magnitudes.
    function automatic logic [63:0] div_nearest(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (r >= den - r)
            q = q + 1;
        return q;
    endfunction

    // Integer square root rounded to nearest.
    function automatic logic [63:0] sqrt_nearest(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (n > res)
            res = res + 1;
        return res;
    endfunction

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v, ref logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] dot_q(input logic signed [63:0] p[3],
                                                 input logic signed [63:0] q[3]);
        return q_mul(p[0], q[0]) + q_mul(p[1], q[1]) + q_mul(p[2], q[2]);
    endfunction

    // Expected response of the vector unit for one command.
    function automatic out_item_t vector_result(input in_item_t c);
        logic signed [63:0] a[3];
        logic signed [63:0] b[3];
        logic signed [63:0] v[3];
        logic signed [63:0] p[3];
        logic signed [63:0] sc;
        logic signed [63:0] lsq;
        logic signed [63:0] d;
        logic signed [63:0] f;
        logic [63:0]        len;
        logic               sat;
        logic               deg;
        out_item_t          r;
        a[0] = c.first_x;
        a[1] = c.first_y;
        a[2] = c.first_z;
        b[0] = c.second_x;
        b[1] = c.second_y;
        b[2] = c.second_z;
        v = '{0, 0, 0};
        p = '{0, 0, 0};
        sc = 0;
        sat = 1'b0;
        deg = 1'b0;
        case (c.func)
            FN_ADD:    for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
            FN_SUB:    for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
            FN_MUL:    for (int i = 0; i < 3; i++) v[i] = q_mul(a[i], b[i]);
            FN_SCALE:  for (int i = 0; i < 3; i++) v[i] = q_mul(a[i], c.scale_factor);
            FN_DOT:    sc = dot_q(a, b);
            FN_LENSQ:  sc = dot_q(a, a);
            FN_LENGTH, FN_NORMALIZE:
            begin
                lsq = dot_q(a, a);
                deg = (lsq == 0) || (lsq < $signed({33'd0, threshold}));
                len = deg ? 64'd0 : sqrt_nearest(64'(lsq) << 16);
                if (c.func == FN_LENGTH)
                    sc = $signed(len);
                else
                    for (int i = 0; i < 3; i++)
                        if (deg)
                            v[i] = a[i];
                        else
                        begin
                            d = $signed(div_nearest(64'(a[i] < 0 ? -a[i] : a[i]) << 16, len));
                            v[i] = a[i] < 0 ? -d : d;
                        end
            end
            FN_PROJECT, FN_REJECT:
            begin
                lsq = dot_q(b, b);
                deg = (lsq == 0) || (lsq < $signed({33'd0, threshold}));
                if (!deg)
                begin
                    d = dot_q(a, b);
                    f = $signed(div_nearest(64'(d < 0 ? -d : d) << 16, 64'(lsq)));
                    f = clamp_q(d < 0 ? -f : f, sat);
                    for (int i = 0; i < 3; i++) p[i] = q_mul(b[i], f);
                end
                for (int i = 0; i < 3; i++)
                    v[i] = (c.func == FN_PROJECT) ? p[i] : a[i] - clamp_q(p[i], sat);
            end
            default: ;
        endcase
        r.out_x = q_t'(clamp_q(v[0], sat));
        r.out_y = q_t'(clamp_q(v[1], sat));
        r.out_z = q_t'(clamp_q(v[2], sat));
        r.out_scalar = q_t'(clamp_q(sc, sat));
        r.saturated = sat;
        r.degenerate = deg;
        return r;
    endfunction

    function automatic q_t random_q(input int small_bias);
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return q_t'($urandom_range(0, 3)) - 1;
            default: ;
        endcase
        if ($urandom_range(0, 9) < small_bias)
            return q_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        return q_t'($urandom);
    endfunction

    function automatic in_item_t random_cmd();
        in_item_t c;
        c.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(FN_ADD, FN_REJECT));
        c.first_x = random_q(6);
        c.first_y = random_q(6);
        c.first_z = random_q(6);
        c.second_x = random_q(6);
        c.second_y = random_q(6);
        c.second_z = random_q(6);
        c.scale_factor = random_q(5);
        return c;
    endfunction

    // Send one command in a burst-and-gap pattern.
    task automatic send_cmd(input in_item_t c, input logic has_known, input out_item_t known);
        if ($urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= c.func;
        cmd_ch.first_x <= c.first_x;
        cmd_ch.first_y <= c.first_y;
        cmd_ch.first_z <= c.first_z;
        cmd_ch.second_x <= c.second_x;
        cmd_ch.second_y <= c.second_y;
        cmd_ch.second_z <= c.second_z;
        cmd_ch.scale_factor <= c.scale_factor;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_results.push_back(has_known ? known : vector_result(c));
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [30:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        threshold = value;
    endtask

    // Response checking against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with none expected, actual %h %h %h %h %b %b", $time,
                         rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.out_scalar,
                         rsp_ch.saturated, rsp_ch.degenerate);
                error_count++;
            end
            else
            begin
                out_item_t e;
                e = pending_results.pop_front();
                result_count++;
                if (rsp_ch.out_x !== e.out_x || rsp_ch.out_y !== e.out_y ||
                    rsp_ch.out_z !== e.out_z || rsp_ch.out_scalar !== e.out_scalar ||
                    rsp_ch.saturated !== e.saturated || rsp_ch.degenerate !== e.degenerate)
                begin
                    $display("%0t: mismatch expected %h %h %h %h %b %b actual %h %h %h %h %b %b",
                             $time, e.out_x, e.out_y, e.out_z, e.out_scalar, e.saturated,
                             e.degenerate, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                             rsp_ch.out_scalar, rsp_ch.saturated, rsp_ch.degenerate);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: long free-running stretches alternate with random stalls.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (stall_mode)
            rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        else
            rsp_ch.ready <= 1'b1;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        logic [30:0] settings[5];
        out_item_t zero_out;

        rst_n = 1'b0;
        error_count = 0;
        result_count = 0;
        threshold = THR_RESET;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FN_ADD;
        cmd_ch.first_x = 0;
        cmd_ch.first_y = 0;
        cmd_ch.first_z = 0;
        cmd_ch.second_x = 0;
        cmd_ch.second_y = 0;
        cmd_ch.second_z = 0;
        cmd_ch.scale_factor = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed-in results where they are obvious.
        zero_out = '0;
        row.has_known = 1'b0;
        row.known = zero_out;
        for (int f = 0; f < 16; f++)
        begin
            row.cmd = '{4'(f), 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000,
                        32'sh0003_0000, 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000};
            row.has_known = (f > FN_REJECT);
            rows.push_back(row);
        end
        // Zero vectors: degenerate length, project to zero, reject pass-through.
        row.has_known = 1'b1;
        row.cmd = '{FN_LENGTH, 0, 0, 0, 0, 0, 0, 0};
        row.known = zero_out;
        row.known.degenerate = 1'b1;
        rows.push_back(row);
        row.cmd = '{FN_PROJECT, 32'sh0001_0000, 0, 0, 0, 0, 0, 0};
        rows.push_back(row);
        row.cmd = '{FN_REJECT, Q_MAX, Q_MIN, 5, 0, 0, 0, 0};
        row.known.out_x = Q_MAX;
        row.known.out_y = Q_MIN;
        row.known.out_z = 5;
        rows.push_back(row);
        // Extreme operands; the sum saturates.
        row.cmd = '{FN_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 0, 0};
        row.known = '{Q_MAX, Q_MIN, Q_MAX, 0, 1'b1, 1'b0};
        rows.push_back(row);
        row.has_known = 1'b0;
        row.cmd = '{FN_SCALE, Q_MIN, Q_MAX, -1, 0, 0, 0, Q_MIN};
        rows.push_back(row);
        row.cmd = '{FN_LENSQ, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0};
        rows.push_back(row);
        row.cmd = '{FN_NORMALIZE, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, 0};
        rows.push_back(row);
        row.cmd = '{FN_PROJECT, Q_MAX, Q_MAX, Q_MAX, 1, 0, 0, 0};
        rows.push_back(row);
        row.cmd = '{FN_REJECT, Q_MIN, Q_MAX, 1, 1, 1, 0, 0};
        rows.push_back(row);
        foreach (rows[i])
            send_cmd(rows[i].cmd, rows[i].has_known, rows[i].known);
        drain_results();

        // Random phases across several threshold settings.
        settings = '{31'd0, 31'h7FFF_FFFF, 31'h0001_0000, 31'd1, 31'($urandom)};
        foreach (settings[k])
        begin
            write_threshold(settings[k]);
            for (int n = 0; n < N_RANDOM / 5; n++)
                send_cmd(random_cmd(), 1'b0, zero_out);
            drain_results();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
